// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, suspended while reset is high.
`define TAQ_CHECK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define TAQ_CHECK_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/taq_pkg.sv -----
// Types, codes and key comparison for the timed action queue.
`default_nettype none
package taq_pkg;

   localparam int TIME_W     = 32;
   localparam int ORDER_W    = 16;
   localparam int CODE_W     = 3;
   localparam int ARG_W      = 32;
   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 88;
   localparam int RESULT_LIMIT = 16;

   localparam logic MODE_ADD      = 1'b0;
   localparam logic MODE_TICK     = 1'b1;
   localparam logic KIND_STATUS   = 1'b0;
   localparam logic KIND_RELEASE  = 1'b1;
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_FULL   = 1'b1;

   typedef struct packed {
      logic [ARG_W-1:0]   ent_argument;
      logic [CODE_W-1:0]  ent_code;
      logic [ORDER_W-1:0] ent_order;
      logic [TIME_W-1:0]  ent_time;
   } entry_type;

   // True when key a sorts strictly before key b.
   function automatic logic key_before(entry_type a, entry_type b);
      logic result;
      if (a.ent_time != b.ent_time) begin
         result = (a.ent_time < b.ent_time);
      end else begin
         result = (a.ent_order < b.ent_order);
      end
      return result;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/taq_entry_ram.sv -----
// Entry storage for the timed action queue, one write and one registered read port.
`default_nettype none
module taq_entry_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire                   clock,
   input  wire                   wr_en,
   input  wire [AW-1:0]          wr_addr,
   input  taq_pkg::entry_type    wr_data,
   input  wire                   rd_en,
   input  wire [AW-1:0]          rd_addr,
   output taq_pkg::entry_type    rd_data
);

   taq_pkg::entry_type mem_ff [DEPTH];
   taq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/core/timed_action_queue_unit.sv -----
// Top level of the timed action queue: sorted insert and due-time release.
//
//   channel | dir | beat contents
//   req_*   | in  | tuser mode, tdata add fields and tick time
//   rsp_*   | out | tuser kind, tdata status and released entry, tlast
//
// An add walks back from the tail, moving each entry that sorts after it up a slot; a full queue drops it.
// A tick walks from the head and releases each due entry until one not yet due or the release limit stops it.
// One read port of the entry memory and one key compare serve both walks.
// The result register lets a finished beat wait while the walk continues.
// Reset clears the state, count, head pointer and flags; no memory clearing is needed.
`default_nettype none
`include "assert_macros.svh"
module timed_action_queue_unit #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // [31:0] exec_time, [47:32] order, [50:48] action_code,
   // [82:51] argument, [114:83] current_time, [119:115] zero
   input  wire [taq_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] mode
   input  wire                               req_tuser,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // [0] status, [3:1] out_action, [35:4] out_argument,
   // [67:36] out_time, [83:68] out_order, [87:84] zero
   output logic [taq_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [0] kind
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int MAX_RELEASE = (QUEUE_DEPTH < taq_pkg::RESULT_LIMIT) ?
                                QUEUE_DEPTH : taq_pkg::RESULT_LIMIT;
   localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);
   localparam logic [CW-1:0] MAX_REL_C = CW'(MAX_RELEASE);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_INS_CHK = 3'd1;
   localparam logic [2:0] ST_INS_CMP = 3'd2;
   localparam logic [2:0] ST_ADD_RSP = 3'd3;
   localparam logic [2:0] ST_TK_CHK  = 3'd4;
   localparam logic [2:0] ST_TK_CMP  = 3'd5;
   localparam logic [2:0] ST_TK_FIN  = 3'd6;

   function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(off);
      if (sum >= SW'(QUEUE_DEPTH)) begin
         sum = sum - SW'(QUEUE_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   logic [2:0]          state_ff, state_in;
   logic [AW-1:0]       head_ff, head_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic                full_ff, full_in;
   logic                pend_valid_ff, pend_valid_in;
   logic                out_valid_ff, out_valid_in;
   logic                out_kind_ff, out_kind_in;
   logic                out_status_ff, out_status_in;
   logic                out_last_ff, out_last_in;
   taq_pkg::entry_type  out_entry_ff, out_entry_in;
   taq_pkg::entry_type  new_ff, new_in;
   taq_pkg::entry_type  pend_ff, pend_in;

   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   taq_pkg::entry_type  ram_wr_data;
   logic                ram_rd_en;
   logic [CW-1:0]       rd_off;
   logic [AW-1:0]       ram_rd_addr;
   taq_pkg::entry_type  ram_rd_data;
   taq_pkg::entry_type  req_entry;
   logic                slot_free;
   logic                key_lt;

   taq_entry_ram #(
      .DEPTH (QUEUE_DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_entry.ent_time     = req_tdata[31:0];
   assign req_entry.ent_order    = req_tdata[47:32];
   assign req_entry.ent_code     = req_tdata[50:48];
   assign req_entry.ent_argument = req_tdata[82:51];

   assign slot_free   = !out_valid_ff || rsp_tready;
   assign ram_rd_addr = wrap_add(head_ff, rd_off);
   assign ram_wr_addr = wrap_add(head_ff, pos_ff);
   assign req_tready  = (state_ff == ST_IDLE);
   assign key_lt      = taq_pkg::key_before(new_ff, ram_rd_data);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      full_in       = full_ff;
      pend_valid_in = pend_valid_ff;
      new_in        = new_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_kind_in   = out_kind_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      out_entry_in  = out_entry_ff;
      ram_wr_en     = 1'b0;
      ram_wr_data   = new_ff;
      ram_rd_en     = 1'b0;
      rd_off        = pos_ff - CW'(1);
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == taq_pkg::MODE_ADD) begin
                  new_in   = req_entry;
                  pos_in   = count_ff;
                  full_in  = (count_ff == DEPTH_C);
                  state_in = (count_ff == DEPTH_C) ? ST_ADD_RSP : ST_INS_CHK;
               end else begin
                  // The tick time is held as a key with the largest order, so an entry
                  // is due when that key does not sort before it.
                  new_in.ent_time  = req_tdata[114:83];
                  new_in.ent_order = '1;
                  pos_in           = '0;
                  pend_valid_in    = 1'b0;
                  state_in         = ST_TK_CHK;
               end
            end
         end
         ST_INS_CHK: begin
            if (pos_ff == '0) begin
               ram_wr_en = 1'b1;
               count_in  = count_ff + CW'(1);
               state_in  = ST_ADD_RSP;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            ram_wr_en = 1'b1;
            if (key_lt) begin
               ram_wr_data = ram_rd_data;
               pos_in      = pos_ff - CW'(1);
               state_in    = ST_INS_CHK;
            end else begin
               count_in = count_ff + CW'(1);
               state_in = ST_ADD_RSP;
            end
         end
         ST_ADD_RSP: begin
            if (slot_free) begin
               out_valid_in  = 1'b1;
               out_kind_in   = taq_pkg::KIND_STATUS;
               out_status_in = full_ff;
               out_last_in   = 1'b1;
               out_entry_in  = '0;
               state_in      = ST_IDLE;
            end
         end
         ST_TK_CHK: begin
            rd_off = pos_ff;
            if ((pos_ff < count_ff) && (pos_ff < MAX_REL_C)) begin
               ram_rd_en = 1'b1;
               state_in  = ST_TK_CMP;
            end else begin
               state_in = ST_TK_FIN;
            end
         end
         ST_TK_CMP: begin
            if (!key_lt) begin
               if (!pend_valid_ff) begin
                  pend_in       = ram_rd_data;
                  pend_valid_in = 1'b1;
                  pos_in        = pos_ff + CW'(1);
                  state_in      = ST_TK_CHK;
               end else if (slot_free) begin
                  out_valid_in  = 1'b1;
                  out_kind_in   = taq_pkg::KIND_RELEASE;
                  out_status_in = taq_pkg::STATUS_OK;
                  out_last_in   = 1'b0;
                  out_entry_in  = pend_ff;
                  pend_in       = ram_rd_data;
                  pos_in        = pos_ff + CW'(1);
                  state_in      = ST_TK_CHK;
               end
            end else begin
               state_in = ST_TK_FIN;
            end
         end
         ST_TK_FIN: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               out_valid_in  = 1'b1;
               out_kind_in   = taq_pkg::KIND_RELEASE;
               out_status_in = taq_pkg::STATUS_OK;
               out_last_in   = 1'b1;
               out_entry_in  = pend_ff;
               pend_valid_in = 1'b0;
               head_in       = wrap_add(head_ff, pos_ff);
               count_in      = count_ff - pos_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         pos_ff        <= '0;
         full_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         pos_ff        <= pos_in;
         full_ff       <= full_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      new_ff        <= new_in;
      pend_ff       <= pend_in;
      out_kind_ff   <= out_kind_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
      out_entry_ff  <= out_entry_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {4'b0000, out_entry_ff.ent_order, out_entry_ff.ent_time,
                        out_entry_ff.ent_argument, out_entry_ff.ent_code, out_status_ff};

   `TAQ_CHECK(a_count_bound, clock, reset, count_ff <= DEPTH_C, "entry count exceeds depth")
   `TAQ_CHECK(a_status_last, clock, reset,
      (rsp_tvalid && (rsp_tuser == taq_pkg::KIND_STATUS)) |-> rsp_tlast,
      "add status beat without last")
   `TAQ_CHECK(a_full_keeps, clock, reset,
      (req_tvalid && req_tready && (req_tuser == taq_pkg::MODE_ADD) &&
       (count_ff == DEPTH_C)) |=> $stable(count_ff),
      "dropped add changed the entry count")
   `TAQ_CHECK(a_pend_in_tick, clock, reset,
      pend_valid_ff |-> ((state_ff == ST_TK_CHK) || (state_ff == ST_TK_CMP) ||
                         (state_ff == ST_TK_FIN)),
      "held release outside a tick walk")

endmodule
`default_nettype wire
